@@ sv/pvt_pkg.sv @@
// Shared types, field widths and operation codes for the voice table.
package pvt_pkg;

  localparam int NUM_VOICES_DEF = 8;

  localparam int OP_W    = 3;
  localparam int VI_W    = 8;
  localparam int NOTE_W  = 7;
  localparam int FOUND_W = 6;
  localparam int COUNT_W = 7;
  localparam int STAMP_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_ASSIGN        = 3'd0,
    OP_RELEASE_VOICE = 3'd1,
    OP_RELEASE_NOTE  = 3'd2,
    OP_SET_RELEASE   = 3'd3,
    OP_FIND_NOTE     = 3'd4,
    OP_FIND_FREE     = 3'd5,
    OP_FIND_OLDEST   = 3'd6,
    OP_QUERY         = 3'd7
  } pvt_op_t;

  // Write request into the voice store
  typedef struct packed {
    logic               en_all;   // note, release flag and stamp
    logic               en_rel;   // release flag only
    logic               set_act;
    logic               clr_act;
    logic [FOUND_W-1:0] idx;
    logic [NOTE_W-1:0]  note;
    logic               rel;
    logic [STAMP_W-1:0] stamp;
  } pvt_wr_t;

  // Registered read data of one voice
  typedef struct packed {
    logic               active;
    logic [NOTE_W-1:0]  note;
    logic               rel;
    logic [STAMP_W-1:0] stamp;
  } pvt_rd_t;

  // Compare unit results
  typedef struct packed {
    logic               note_hit;
    logic               is_free;
    logic               older;
    logic [STAMP_W-1:0] eff_stamp;
  } pvt_cmp_t;

endpackage

@@ sv/pvt_if.sv @@
// Request and result channel interfaces of the voice table.
interface pvt_in_if;
  import pvt_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [VI_W-1:0]   voice_index;
  logic [NOTE_W-1:0] note;
  logic              release_flag;

  modport source (output valid, op, voice_index, note, release_flag, input ready);
  modport sink   (input valid, op, voice_index, note, release_flag, output ready);
endinterface

interface pvt_out_if;
  import pvt_pkg::*;
  logic               valid;
  logic               ready;
  logic               ok;
  logic [FOUND_W-1:0] voice_found;
  logic [NOTE_W-1:0]  note_out;
  logic               note_valid;
  logic               active_out;
  logic               releasing_out;
  logic [COUNT_W-1:0] active_count;

  modport source (output valid, ok, voice_found, note_out, note_valid, active_out,
                  releasing_out, active_count, input ready);
  modport sink   (input valid, ok, voice_found, note_out, note_valid, active_out,
                  releasing_out, active_count, output ready);
endinterface

@@ sv/pvt_voice_mem.sv @@
// Voice store: note/flag/stamp memory, active flags and active-voice count.
module pvt_voice_mem #(
  parameter int NUM_VOICES = pvt_pkg::NUM_VOICES_DEF,
  parameter int IW         = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pvt_pkg::pvt_wr_t            wr,
  input  logic                        rd_en,
  input  logic [IW-1:0]               rd_idx,
  output pvt_pkg::pvt_rd_t            rd_data,
  output logic [pvt_pkg::COUNT_W-1:0] active_count
);
  import pvt_pkg::*;

  logic [NUM_VOICES-1:0] active_r, active_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NOTE_W-1:0]     note_mem  [NUM_VOICES];
  logic                  rel_mem   [NUM_VOICES];
  logic [STAMP_W-1:0]    stamp_mem [NUM_VOICES];
  pvt_rd_t               rd_data_r;
  logic [IW-1:0]         widx;
  logic                  was_act;

  assign widx    = wr.idx[IW-1:0];
  assign was_act = active_r[widx];

  // active flags and count follow the set/clear requests
  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (wr.set_act) begin
      active_nxt[widx] = 1'b1;
      if (!was_act) cnt_nxt = cnt_r + COUNT_W'(1);
    end else if (wr.clr_act) begin
      active_nxt[widx] = 1'b0;
      if (was_act) cnt_nxt = cnt_r - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr.en_all) begin
      note_mem[widx]  <= wr.note;
      rel_mem[widx]   <= wr.rel;
      stamp_mem[widx] <= wr.stamp;
    end else if (wr.en_rel) begin
      rel_mem[widx] <= wr.rel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.active <= active_r[rd_idx];
      rd_data_r.note   <= note_mem[rd_idx];
      rd_data_r.rel    <= rel_mem[rd_idx];
      rd_data_r.stamp  <= stamp_mem[rd_idx];
    end
  end

  assign rd_data      = rd_data_r;
  assign active_count = cnt_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == COUNT_W'($countones(active_r)))
    else $error("active count out of step with active flags");

  a_no_set_and_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr.set_act && wr.clr_act))
    else $error("voice set and cleared in one write");

endmodule

@@ sv/pvt_cmp_unit.sv @@
// Shared compare unit: note match, free check and stamp age compare.
module pvt_cmp_unit (
  input  logic [pvt_pkg::NOTE_W-1:0]  key_note,
  input  pvt_pkg::pvt_rd_t            rd,
  input  logic [pvt_pkg::STAMP_W-1:0] best_stamp,
  output pvt_pkg::pvt_cmp_t           res
);
  import pvt_pkg::*;

  logic [STAMP_W-1:0] eff;

  // inactive voices read as stamp 0
  assign eff = rd.active ? rd.stamp : '0;

  always_comb begin
    res.note_hit  = rd.active && (rd.note == key_note);
    res.is_free   = !rd.active;
    res.older     = eff < best_stamp;
    res.eff_stamp = eff;
  end

endmodule

@@ sv/polyphonic_voice_table.sv @@
// Voice table top level: request sequencer around the voice store and compare unit.
//
// Requests arrive on in_ch and one result beat per request leaves on out_ch;
// both use valid/ready, a beat moving when both are high.
// A request is taken only while the sequencer is idle. Assign, release voice,
// set release flag and a rejected index go straight to the result; a query
// reads its voice once; release note, find note, find free and find oldest
// search all voices.
// Searches walk the voices one per cycle through the single read port of the
// voice memory and the shared compare unit; that walk sets the search time.
// The next request is accepted the cycle after the result is loaded into the
// output register, so a request can be taken while the previous result is
// still held. If the receiver stalls, the result stays in the output register
// and a finished search waits until the register is free.
// Reset clears all active flags, the active count and sets the stamp counter
// to one; no memory clearing pass is needed since inactive voices are masked.
module polyphonic_voice_table #(
  parameter int NUM_VOICES = pvt_pkg::NUM_VOICES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pvt_in_if.sink    in_ch,
  pvt_out_if.source out_ch
);
  import pvt_pkg::*;

  localparam int IW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_RESP} state_t;

  state_t             state_r, state_nxt;
  pvt_op_t            op_r, op_nxt, in_op;
  logic [NOTE_W-1:0]  key_r, key_nxt;
  logic [IW-1:0]      scan_r, scan_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]      rd_idx_r, rd_idx_nxt;
  logic               ok_r, ok_nxt;
  logic [IW-1:0]      found_r, found_nxt;
  logic [STAMP_W-1:0] best_r, best_nxt;
  logic [NOTE_W-1:0]  qnote_r, qnote_nxt;
  logic               qact_r, qact_nxt;
  logic               qrel_r, qrel_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic [FOUND_W-1:0] out_found_r, out_found_nxt;
  logic [NOTE_W-1:0]  out_note_r, out_note_nxt;
  logic               out_act_r, out_act_nxt;
  logic               out_rel_r, out_rel_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  pvt_wr_t            wr;
  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  pvt_rd_t            rd_data;
  pvt_cmp_t           cmp;
  logic [COUNT_W-1:0] act_cnt;
  logic               vi_ok;
  logic               rel_hit;

  pvt_voice_mem #(.NUM_VOICES(NUM_VOICES), .IW(IW)) u_mem (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr           (wr),
    .rd_en        (rd_en),
    .rd_idx       (rd_addr),
    .rd_data      (rd_data),
    .active_count (act_cnt)
  );

  pvt_cmp_unit u_cmp (
    .key_note   (key_r),
    .rd         (rd_data),
    .best_stamp (best_r),
    .res        (cmp)
  );

  assign in_op   = pvt_op_t'(in_ch.op);
  assign vi_ok   = in_ch.voice_index < VI_W'(NUM_VOICES);
  assign rel_hit = (op_r == OP_RELEASE_NOTE) && ok_r;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.ok            = out_ok_r;
  assign out_ch.voice_found   = out_found_r;
  assign out_ch.note_out      = out_note_r;
  assign out_ch.note_valid    = out_act_r;
  assign out_ch.active_out    = out_act_r;
  assign out_ch.releasing_out = out_rel_r;
  assign out_ch.active_count  = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    scan_nxt      = scan_r;
    ok_nxt        = ok_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    qnote_nxt     = qnote_r;
    qact_nxt      = qact_r;
    qrel_nxt      = qrel_r;
    stamp_nxt     = stamp_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_found_nxt = out_found_r;
    out_note_nxt  = out_note_r;
    out_act_nxt   = out_act_r;
    out_rel_nxt   = out_rel_r;
    out_cnt_nxt   = out_cnt_r;
    wr            = '0;
    rd_en         = 1'b0;
    rd_addr       = scan_r;
    rd_vld_nxt    = 1'b0;

    // fold in the voice read last cycle
    if (rd_vld_r) begin
      case (op_r)
        OP_RELEASE_NOTE, OP_FIND_NOTE: begin
          if (!ok_r && cmp.note_hit) begin
            ok_nxt    = 1'b1;
            found_nxt = rd_idx_r;
          end
        end
        OP_FIND_FREE: begin
          if (!ok_r && cmp.is_free) begin
            ok_nxt    = 1'b1;
            found_nxt = rd_idx_r;
          end
        end
        OP_FIND_OLDEST: begin
          if ((rd_idx_r == '0) || cmp.older) begin
            best_nxt  = cmp.eff_stamp;
            found_nxt = rd_idx_r;
          end
        end
        OP_QUERY: begin
          qact_nxt  = rd_data.active;
          qnote_nxt = rd_data.active ? rd_data.note : '0;
          qrel_nxt  = rd_data.active && rd_data.rel;
        end
        default: ;
      endcase
    end

    // result register drains independently
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_op;
          key_nxt   = in_ch.note;
          scan_nxt  = '0;
          ok_nxt    = 1'b0;
          found_nxt = '0;
          best_nxt  = '0;
          qnote_nxt = '0;
          qact_nxt  = 1'b0;
          qrel_nxt  = 1'b0;
          wr.idx    = in_ch.voice_index[FOUND_W-1:0];
          state_nxt = ST_RESP;
          case (in_op)
            OP_ASSIGN: begin
              if (vi_ok) begin
                wr.en_all = 1'b1;
                wr.set_act = 1'b1;
                wr.note   = in_ch.note;
                wr.stamp  = stamp_r;
                stamp_nxt = stamp_r + STAMP_W'(1);
                ok_nxt    = 1'b1;
              end
            end
            OP_RELEASE_VOICE: begin
              if (vi_ok) begin
                wr.en_all  = 1'b1;
                wr.clr_act = 1'b1;
                ok_nxt     = 1'b1;
              end
            end
            OP_SET_RELEASE: begin
              if (vi_ok) begin
                wr.en_rel = 1'b1;
                wr.rel    = in_ch.release_flag;
                ok_nxt    = 1'b1;
              end
            end
            OP_QUERY: begin
              if (vi_ok) begin
                rd_en      = 1'b1;
                rd_addr    = in_ch.voice_index[IW-1:0];
                rd_vld_nxt = 1'b1;
                ok_nxt     = 1'b1;
                state_nxt  = ST_DRAIN;
              end
            end
            OP_FIND_OLDEST: begin
              ok_nxt    = 1'b1;
              state_nxt = ST_SCAN;
            end
            default: state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en      = 1'b1;
        rd_vld_nxt = 1'b1;
        if (scan_r == IW'(NUM_VOICES - 1)) state_nxt = ST_DRAIN;
        else scan_nxt = scan_r + IW'(1);
      end
      ST_DRAIN: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          // release-note clears the hit voice as the result goes out
          if (rel_hit) begin
            wr.en_all  = 1'b1;
            wr.clr_act = 1'b1;
            wr.idx     = FOUND_W'(found_r);
          end
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_found_nxt = FOUND_W'(found_r);
          out_note_nxt  = qnote_r;
          out_act_nxt   = qact_r;
          out_rel_nxt   = qrel_r;
          out_cnt_nxt   = act_cnt - COUNT_W'(rel_hit);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    rd_idx_nxt = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      stamp_r     <= STAMP_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    scan_r      <= scan_nxt;
    rd_idx_r    <= rd_idx_nxt;
    ok_r        <= ok_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    qnote_r     <= qnote_nxt;
    qact_r      <= qact_nxt;
    qrel_r      <= qrel_nxt;
    out_ok_r    <= out_ok_nxt;
    out_found_r <= out_found_nxt;
    out_note_r  <= out_note_nxt;
    out_act_r   <= out_act_nxt;
    out_rel_r   <= out_rel_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  a_drain_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> rd_vld_r)
    else $error("drain state without read data in flight");

  a_drain_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |=> state_r == ST_RESP)
    else $error("drain did not move to result");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ({1'b0, rd_idx_r} < (IW + 1)'(NUM_VOICES)))
    else $error("voice read beyond table");

endmodule
